// ===== sv/assert_macros.svh =====
// assertion macros for the complex magnitude sum rtl, included by cms_accum
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define CMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define CMS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/cms_pkg.sv =====
// package for the complex magnitude sum block
// types and constants shared by the cells, the accumulator and the top level
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

  // default width of one real or imaginary part
  localparam int ELEMENT_BITS_DEF = 32;

  // width of the running sum and of the stride register
  localparam int SUM_W    = 48;
  localparam int STRIDE_W = 12;

  localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

  // sideband travelling down the cell chain with each request
  typedef struct packed {
    logic valid;
    logic last;
    logic empty;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/complex_magnitude_sum.sv =====
// a request passes the squaring cells, then the root cells, then the output register
// throughput: one element per cycle while not stalled, set by the chain of ELEMENT_BITS
//   squaring cells and ELEMENT_BITS root cells, each settling one bit and handing on every cycle
// the chain stalls only while a vector-ending request meets a full, unread output register
// reset (rst_n, synchronous): clears cell valid bits, sum, flag, output valid; stride to 1
`timescale 1ns / 1ps
`default_nettype none

module complex_magnitude_sum #(
  parameter int ELEMENT_BITS = cms_pkg::ELEMENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cms_pkg::STRIDE_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ELEMENT_BITS-1:0]       in_re_part,
  input  logic [ELEMENT_BITS-1:0]       in_im_part,
  input  logic                          in_last,
  input  logic                          in_empty_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cms_pkg::SUM_W-1:0]     out_sum,
  output logic                          out_saturated
);

  localparam int EB = ELEMENT_BITS;
  localparam int SW = 2 * EB;

  logic [cms_pkg::STRIDE_W-1:0] stride_r, stride_nxt;
  logic                         stride_ok;
  logic                         hold, en;
  logic [EB-1:0]                mag_re, mag_im;
  cms_pkg::ctl_t                ctl_head;

  cms_pkg::ctl_t sq_ctl  [0:EB];
  logic [EB-1:0] sq_a    [0:EB];
  logic [EB-1:0] sq_b    [0:EB];
  logic [SW-1:0] sq_s    [0:EB];
  cms_pkg::ctl_t rt_ctl  [0:EB];
  logic [SW-1:0] rt_rem  [0:EB];
  logic [EB-1:0] rt_root [0:EB];

  // stride register, only its sign and zero test matter here
  always_comb begin
    stride_nxt = stride_r;
    if (cfg_wr_en) begin
      stride_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= cms_pkg::STRIDE_RESET;
    end else begin
      stride_r <= stride_nxt;
    end
  end

  assign stride_ok = (stride_r != '0) && !stride_r[cms_pkg::STRIDE_W-1];

  // whole chain moves together unless the output side holds it
  assign en       = !hold;
  assign in_ready = en;

  // magnitudes of the two's complement parts
  assign mag_re = in_re_part[EB-1] ? (~in_re_part + EB'(1)) : in_re_part;
  assign mag_im = in_im_part[EB-1] ? (~in_im_part + EB'(1)) : in_im_part;

  always_comb begin
    ctl_head.valid = in_valid;
    ctl_head.last  = in_last;
    ctl_head.empty = in_empty_req;
  end

  assign sq_ctl[0] = ctl_head;
  assign sq_a[0]   = mag_re;
  assign sq_b[0]   = mag_im;
  assign sq_s[0]   = '0;

  // squaring chain: cell i adds the partial products for bit i
  for (genvar i = 0; i < EB; i++) begin : g_sq
    cms_sq_cell #(
      .ELEMENT_BITS (EB),
      .IDX          (i)
    ) u_sq (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .ctl_in  (sq_ctl[i]),
      .a_in    (sq_a[i]),
      .b_in    (sq_b[i]),
      .s_in    (sq_s[i]),
      .ctl_out (sq_ctl[i+1]),
      .a_out   (sq_a[i+1]),
      .b_out   (sq_b[i+1]),
      .s_out   (sq_s[i+1])
    );
  end

  assign rt_ctl[0]  = sq_ctl[EB];
  assign rt_rem[0]  = sq_s[EB];
  assign rt_root[0] = '0;

  // root chain: most significant result bit first
  for (genvar j = 0; j < EB; j++) begin : g_rt
    cms_sqrt_cell #(
      .ELEMENT_BITS (EB),
      .K            (EB - 1 - j)
    ) u_rt (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_in   (rt_ctl[j]),
      .rem_in   (rt_rem[j]),
      .root_in  (rt_root[j]),
      .ctl_out  (rt_ctl[j+1]),
      .rem_out  (rt_rem[j+1]),
      .root_out (rt_root[j+1])
    );
  end

  // accumulation and result register
  cms_accum #(
    .ELEMENT_BITS (EB)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .fin_ctl       (rt_ctl[EB]),
    .fin_root      (rt_root[EB]),
    .stride_ok     (stride_ok),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_sum       (out_sum),
    .out_saturated (out_saturated),
    .hold          (hold)
  );

endmodule

`default_nettype wire

// ===== sv/cms_sq_cell.sv =====
// one cell of the squaring chain: adds the shifted partial products for one bit of a^2 + b^2
// depends on cms_pkg for the sideband struct
`timescale 1ns / 1ps
`default_nettype none

module cms_sq_cell #(
  parameter int ELEMENT_BITS = cms_pkg::ELEMENT_BITS_DEF,
  parameter int IDX          = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  cms_pkg::ctl_t               ctl_in,
  input  logic [ELEMENT_BITS-1:0]     a_in,
  input  logic [ELEMENT_BITS-1:0]     b_in,
  input  logic [2*ELEMENT_BITS-1:0]   s_in,
  output cms_pkg::ctl_t               ctl_out,
  output logic [ELEMENT_BITS-1:0]     a_out,
  output logic [ELEMENT_BITS-1:0]     b_out,
  output logic [2*ELEMENT_BITS-1:0]   s_out
);

  localparam int SW = 2 * ELEMENT_BITS;

  cms_pkg::ctl_t         ctl_r, ctl_nxt;
  logic [ELEMENT_BITS-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [SW-1:0]         s_r, s_nxt;
  logic [SW-1:0]         pa, pb;

  // partial products for bit IDX of each magnitude
  assign pa = a_in[IDX] ? ({{ELEMENT_BITS{1'b0}}, a_in} << IDX) : '0;
  assign pb = b_in[IDX] ? ({{ELEMENT_BITS{1'b0}}, b_in} << IDX) : '0;

  always_comb begin
    ctl_nxt = ctl_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    s_nxt   = s_r;
    if (en) begin
      ctl_nxt = ctl_in;
      a_nxt   = a_in;
      b_nxt   = b_in;
      s_nxt   = s_in + pa + pb;
    end
  end

  // control reset, payload free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    s_r <= s_nxt;
  end

  assign ctl_out = ctl_r;
  assign a_out   = a_r;
  assign b_out   = b_r;
  assign s_out   = s_r;

endmodule

`default_nettype wire

// ===== sv/cms_sqrt_cell.sv =====
// one cell of the square root chain: settles result bit K by remainder method
// depends on cms_pkg for the sideband struct
`timescale 1ns / 1ps
`default_nettype none

module cms_sqrt_cell #(
  parameter int ELEMENT_BITS = cms_pkg::ELEMENT_BITS_DEF,
  parameter int K            = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  cms_pkg::ctl_t               ctl_in,
  input  logic [2*ELEMENT_BITS-1:0]   rem_in,
  input  logic [ELEMENT_BITS-1:0]     root_in,
  output cms_pkg::ctl_t               ctl_out,
  output logic [2*ELEMENT_BITS-1:0]   rem_out,
  output logic [ELEMENT_BITS-1:0]     root_out
);

  localparam int SW = 2 * ELEMENT_BITS;
  localparam int TW = SW + 1;

  cms_pkg::ctl_t           ctl_r, ctl_nxt;
  logic [SW-1:0]           rem_r, rem_nxt;
  logic [ELEMENT_BITS-1:0] root_r, root_nxt;
  logic [TW-1:0]           trial;
  logic                    take;

  // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
  assign trial = ({{(ELEMENT_BITS+1){1'b0}}, root_in} << (K + 1))
               + ({{(TW-1){1'b0}}, 1'b1} << (2 * K));
  assign take  = {1'b0, rem_in} >= trial;

  always_comb begin
    ctl_nxt  = ctl_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (en) begin
      ctl_nxt  = ctl_in;
      rem_nxt  = take ? (rem_in - trial[SW-1:0]) : rem_in;
      root_nxt = take ? (root_in | ({{(ELEMENT_BITS-1){1'b0}}, 1'b1} << K)) : root_in;
    end
  end

  // control reset, payload free running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign ctl_out  = ctl_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

`default_nettype wire

// ===== sv/cms_accum.sv =====
// saturating accumulator and output register at the end of the cell chain
// depends on cms_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cms_accum #(
  parameter int ELEMENT_BITS = cms_pkg::ELEMENT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cms_pkg::ctl_t               fin_ctl,
  input  logic [ELEMENT_BITS-1:0]     fin_root,
  input  logic                        stride_ok,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [cms_pkg::SUM_W-1:0]   out_sum,
  output logic                        out_saturated,
  output logic                        hold
);

  localparam int SW = cms_pkg::SUM_W;

  logic [SW-1:0] acc_r, acc_nxt;
  logic          sat_r, sat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;
  logic          out_sat_r, out_sat_nxt;
  logic [SW:0]   sum_wide;
  logic [SW-1:0] add_acc;
  logic          add_sat;
  logic          emit, step;

  // a request that ends a vector needs the output register free
  assign emit = fin_ctl.valid && (fin_ctl.last || fin_ctl.empty);
  assign hold = emit && out_valid_r && !out_ready;
  assign step = fin_ctl.valid && !hold;

  // saturating add of the modulus
  assign sum_wide = {1'b0, acc_r} + {{(SW+1-ELEMENT_BITS){1'b0}}, fin_root};
  assign add_acc  = sum_wide[SW] ? cms_pkg::SUM_MAX : sum_wide[SW-1:0];
  assign add_sat  = sum_wide[SW] | sat_r;

  always_comb begin
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;
    if (step) begin
      if (fin_ctl.empty) begin
        acc_nxt       = '0;
        sat_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        out_sum_nxt   = '0;
        out_sat_nxt   = 1'b0;
      end else if (fin_ctl.last) begin
        acc_nxt       = '0;
        sat_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        out_sum_nxt   = stride_ok ? add_acc : '0;
        out_sat_nxt   = stride_ok && add_sat;
      end else begin
        acc_nxt = add_acc;
        sat_nxt = add_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sum       = out_sum_r;
  assign out_saturated = out_sat_r;

  // saturation flag only with the sum pinned at its maximum
  `CMS_ASSERT(a_sat_acc_max, !sat_r || acc_r == cms_pkg::SUM_MAX, "sat set below max")
  `CMS_ASSERT(a_out_sat_max, !(out_valid_r && out_sat_r) || out_sum_r == cms_pkg::SUM_MAX, "saturated result below max")
  // no result appears unless a vector ended
  `CMS_ASSERT_NEXT(a_no_extra, !out_valid_r && !emit, !out_valid_r, "result without vector end")

endmodule

`default_nettype wire

// ===== verif/complex_magnitude_sum_test.sv =====
// self-checking testbench for complex_magnitude_sum: streams complex requests,
// predicts each vector's saturated sum of moduli and compares every result
// depends on cms_pkg and the complex_magnitude_sum rtl only
`timescale 1ns / 1ps

module complex_magnitude_sum_test;

  localparam int EW = cms_pkg::ELEMENT_BITS_DEF;
  // pipeline depth of the block plus margin, used before stride writes and at the end
  localparam int HOLD_OFF = 2 * EW + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTS = 100;
  // number of non-final elements in the back to back run of maximum-modulus elements
  localparam int MAX_RUN = 24;

  typedef logic [EW-1:0] part_t;
  typedef logic [cms_pkg::SUM_W-1:0] sum_t;
  typedef logic [cms_pkg::STRIDE_W-1:0] stride_t;
  typedef logic [2*EW+1:0] energy_t;

  localparam part_t PART_MOST_NEG = {1'b1, {(EW-1){1'b0}}};
  localparam part_t PART_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam stride_t STRIDE_ZERO = '0;
  localparam stride_t STRIDE_MINUS_ONE = '1;
  localparam stride_t STRIDE_MOST_NEG = {1'b1, {(cms_pkg::STRIDE_W-1){1'b0}}};
  localparam stride_t STRIDE_MOST_POS = {1'b0, {(cms_pkg::STRIDE_W-1){1'b1}}};
  localparam stride_t STRIDE_LOW = -stride_t'(1024);
  localparam stride_t STRIDE_HIGH = stride_t'(1024);

  typedef struct packed {
    sum_t sum;
    logic sat;
  } sum_result_t;

  typedef enum logic {ROW_REQUEST, ROW_STRIDE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    stride_t     stride;
    part_t       re;
    part_t       im;
    logic        last;
    logic        empty;
    logic        typed;
    sum_result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    cfg_wr_en;
  stride_t cfg_wr_data;
  logic    in_valid;
  logic    in_ready;
  part_t   in_re_part;
  part_t   in_im_part;
  logic    in_last;
  logic    in_empty_req;
  logic    out_valid;
  logic    out_ready;
  sum_t    out_sum;
  logic    out_saturated;

  // predictor state
  sum_t    run_sum;
  logic    run_sat;
  stride_t stride_q;

  sum_result_t pending_sums[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  complex_magnitude_sum u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_re_part   (in_re_part),
    .in_im_part   (in_im_part),
    .in_last      (in_last),
    .in_empty_req (in_empty_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sum      (out_sum),
    .out_saturated(out_saturated)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // absolute value of a two's complement part, one bit wider
  function automatic logic [EW:0] part_magnitude(part_t v);
    return v[EW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  // floor of sqrt(re^2 + im^2), bit by bit from the top
  function automatic sum_t element_modulus(part_t re, part_t im);
    energy_t a, b, energy, root, trial;
    a = energy_t'(part_magnitude(re));
    b = energy_t'(part_magnitude(im));
    energy = a * a + b * b;
    root = '0;
    for (int i = EW; i >= 0; i--) begin
      trial = root | (energy_t'(1) << i);
      if (trial * trial <= energy) root = trial;
    end
    return sum_t'(root);
  endfunction

  // fold one request into the running sum; returns 1 when it ends a vector
  function automatic bit fold_request(part_t re, part_t im, logic last, logic empty,
                                      output sum_result_t res);
    sum_t m;
    res = '0;
    if (empty) begin
      run_sum = '0;
      run_sat = 1'b0;
      return 1'b1;
    end
    m = element_modulus(re, im);
    if (m > cms_pkg::SUM_MAX - run_sum) begin
      run_sum = cms_pkg::SUM_MAX;
      run_sat = 1'b1;
    end else begin
      run_sum = run_sum + m;
    end
    if (!last) return 1'b0;
    // non-positive stride forces a zero result
    if (stride_q != STRIDE_ZERO && !stride_q[cms_pkg::STRIDE_W-1]) begin
      res.sum = run_sum;
      res.sat = run_sat;
    end
    run_sum = '0;
    run_sat = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t req_row(part_t re, part_t im, logic last, logic empty);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REQUEST;
    r.re = re;
    r.im = im;
    r.last = last;
    r.empty = empty;
    return r;
  endfunction

  function automatic stim_row_t typed_row(part_t re, part_t im, logic last, logic empty,
                                         sum_t sum, logic sat);
    stim_row_t r;
    r = req_row(re, im, last, empty);
    r.typed = 1'b1;
    r.want.sum = sum;
    r.want.sat = sat;
    return r;
  endfunction

  function automatic stim_row_t stride_row(stride_t value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_STRIDE;
    r.stride = value;
    return r;
  endfunction

  // mixes extremes, small values and full random words
  function automatic part_t rand_part();
    case ($urandom_range(0, 7))
      0: return PART_MOST_NEG;
      1: return PART_MAX;
      2: return '0;
      3: return '1;
      4: return part_t'($urandom_range(0, 'h3_FFFF));
      5: return -part_t'($urandom_range(0, 'h3_FFFF));
      default: return part_t'($urandom);
    endcase
  endfunction

  function automatic stride_t rand_stride();
    case ($urandom_range(0, 9))
      0: return STRIDE_ZERO;
      1: return STRIDE_MINUS_ONE;
      2: return STRIDE_LOW;
      3: return STRIDE_HIGH;
      4: return STRIDE_MOST_NEG;
      5: return STRIDE_MOST_POS;
      6: return cms_pkg::STRIDE_RESET;
      default: return stride_t'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input sum_t got, input sum_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // drive one request, after a random gap while tx_idle is set, and record what it should produce
  task automatic push_request(part_t re, part_t im, logic last, logic empty,
                              logic typed = 1'b0, sum_result_t want = '0);
    int gap;
    sum_result_t res;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_re_part   <= re;
    in_im_part   <= im;
    in_last      <= last;
    in_empty_req <= empty;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (fold_request(re, im, last, empty, res))
      pending_sums.push_back(typed ? want : res);
  endtask

  // stride write once the block has drained
  task automatic write_stride(stride_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stride_q = value;
  endtask

  // result checking and activity watch
  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected result sum", out_sum, '0);
      end else begin
        want = pending_sums.pop_front();
        if (out_sum !== want.sum) report_mismatch("sum", out_sum, want.sum);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", sum_t'(out_saturated), sum_t'(want.sat));
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("complex_magnitude_sum_test NOT OK");
    $finish;
  end

  // result side: random stall before each result while rx_idle is set
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    int kind;
    int len;
    int sent;
    stim_row_t row;

    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_re_part   = '0;
    in_im_part   = '0;
    in_last      = 1'b0;
    in_empty_req = 1'b0;
    run_sum      = '0;
    run_sat      = 1'b0;
    stride_q     = cms_pkg::STRIDE_RESET;

    directed_rows = '{
      // zero element straight after reset
      typed_row('0, '0, 1'b1, 1'b0, '0, 1'b0),
      // 3-4-5 triangle in Q16.16
      typed_row(part_t'(3 << 16), part_t'(4 << 16), 1'b1, 1'b0, sum_t'(5 << 16), 1'b0),
      typed_row(part_t'(1), part_t'(1), 1'b1, 1'b0, sum_t'(1), 1'b0),
      // most negative part on either side
      typed_row(PART_MOST_NEG, '0, 1'b1, 1'b0, sum_t'(1) << (EW - 1), 1'b0),
      typed_row('0, PART_MOST_NEG, 1'b1, 1'b0, sum_t'(1) << (EW - 1), 1'b0),
      req_row(PART_MOST_NEG, PART_MOST_NEG, 1'b1, 1'b0),
      req_row(PART_MAX, PART_MAX, 1'b1, 1'b0),
      // three-element vector with mixed signs
      req_row('1, part_t'(1), 1'b0, 1'b0),
      req_row(part_t'('h1_2345), -part_t'('h1_2346), 1'b0, 1'b0),
      req_row(part_t'(5), '0, 1'b1, 1'b0),
      // empty vector on its own
      typed_row('0, '0, 1'b0, 1'b1, '0, 1'b0),
      // empty request discards a partial sum and ignores its fields
      req_row(part_t'('h10_0000), '0, 1'b0, 1'b0),
      typed_row('1, '1, 1'b1, 1'b1, '0, 1'b0),
      // zero and negative strides force zero results, positive strides restore them
      stride_row(STRIDE_ZERO),
      typed_row(part_t'(5 << 16), '0, 1'b1, 1'b0, '0, 1'b0),
      req_row(PART_MAX, PART_MOST_NEG, 1'b0, 1'b0),
      typed_row('0, '0, 1'b0, 1'b1, '0, 1'b0),
      stride_row(STRIDE_MINUS_ONE),
      typed_row(PART_MOST_NEG, PART_MAX, 1'b1, 1'b0, '0, 1'b0),
      stride_row(STRIDE_MOST_NEG),
      typed_row(part_t'('h1234), part_t'('h5678), 1'b1, 1'b0, '0, 1'b0),
      stride_row(STRIDE_MOST_POS),
      req_row(part_t'('hAAAA_AAAA), part_t'('h5555_5555), 1'b1, 1'b0),
      stride_row(STRIDE_HIGH),
      req_row('0, '0, 1'b0, 1'b0),
      typed_row('0, part_t'(1), 1'b1, 1'b0, sum_t'(1), 1'b0)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_STRIDE)
        write_stride(row.stride);
      else
        push_request(row.re, row.im, row.last, row.empty, row.typed, row.want);
    end

    // one vector of maximum moduli, back to back
    write_stride(cms_pkg::STRIDE_RESET);
    tx_idle = 1'b0;
    repeat (MAX_RUN) push_request(PART_MOST_NEG, PART_MOST_NEG, 1'b0, 1'b0);
    push_request(PART_MOST_NEG, PART_MOST_NEG, 1'b1, 1'b0);

    // random phases, each under its own stride; one phase runs without gaps
    for (int phase = 0; phase < 6; phase++) begin
      write_stride(rand_stride());
      tx_idle = (phase != 2);
      rx_idle = (phase != 2);
      sent = 0;
      while (sent < 60) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          // stray empty request with random fields
          push_request(rand_part(), rand_part(), 1'($urandom), 1'b1);
          sent++;
        end else begin
          // kind 1 leaves the vector unterminated
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            push_request(rand_part(), rand_part(), (kind != 1) && (k == len - 1), 1'b0);
            sent++;
          end
        end
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    if (mismatch_count == 0)
      $display("complex_magnitude_sum_test OK");
    else
      $display("complex_magnitude_sum_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cms_pkg.sv
sv/cms_sq_cell.sv
sv/cms_sqrt_cell.sv
sv/cms_accum.sv
sv/complex_magnitude_sum.sv
verif/complex_magnitude_sum_test.sv
